/* hw/rtl/rlc_am_pdu_deframer_assert.svh */
// assertion macros used by the deframer result queue
`ifndef RLC_AM_PDU_DEFRAMER_ASSERT_SVH
`define RLC_AM_PDU_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RLCAM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlcam same-cycle check failed");

// next-cycle implication, checked outside reset
`define RLCAM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlcam next-cycle check failed");

`endif

/* hw/rtl/rlcam_pkg.sv */
`default_nettype none
package rlcam_pkg;

    // parse phases
    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_SO0  = 3'd2,
        PH_SO1  = 3'd3,
        PH_LIA  = 3'd4,
        PH_LIB  = 3'd5,
        PH_LIC  = 3'd6,
        PH_DATA = 3'd7
    } phase_t;

    // result status codes
    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_CONTROL = 2'd1;
    localparam logic [1:0] ST_TOOMANY = 2'd2;
    localparam logic [1:0] ST_TRUNC   = 2'd3;

    // one result item
    typedef struct packed {
        logic [7:0]  byte_out;
        logic [3:0]  seg_index;
        logic [9:0]  seq_num;
        logic        resegmented;
        logic        poll_bit;
        logic [1:0]  framing_info;
        logic        last_seg_flag;
        logic [14:0] seg_offset;
        logic        seg_start;
        logic        seg_end;
        logic [1:0]  status;
        logic        pdu_end;
    } res_t;

endpackage
`default_nettype wire

/* hw/rtl/rlcam_if.sv */
`default_nettype none
// pdu byte channel
interface rlcam_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] pdu_byte;
    logic       pdu_last;
    modport source (output valid, output pdu_byte, output pdu_last, input ready);
    modport sink (input valid, input pdu_byte, input pdu_last, output ready);
endinterface

// result channel
interface rlcam_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic [3:0]  seg_index;
    logic [9:0]  seq_num;
    logic        resegmented;
    logic        poll_bit;
    logic [1:0]  framing_info;
    logic        last_seg_flag;
    logic [14:0] seg_offset;
    logic        seg_start;
    logic        seg_end;
    logic [1:0]  status;
    logic        pdu_end;
    modport source (output valid, output byte_out, output seg_index, output seq_num,
                    output resegmented, output poll_bit, output framing_info,
                    output last_seg_flag, output seg_offset, output seg_start,
                    output seg_end, output status, output pdu_end, input ready);
    modport sink (input valid, input byte_out, input seg_index, input seq_num,
                  input resegmented, input poll_bit, input framing_info,
                  input last_seg_flag, input seg_offset, input seg_start,
                  input seg_end, input status, input pdu_end, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rlcam_parser.sv */
`default_nettype none
module rlcam_parser #(
    parameter int MAX_SEGMENTS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       pdu_byte,
    input  wire logic             pdu_last,
    output rlcam_pkg::res_t       res,
    output logic                  res_valid
);

    localparam int CW = $clog2(MAX_SEGMENTS) + 1;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam logic [CW:0] MAX_V = (CW + 1)'(MAX_SEGMENTS);

    rlcam_pkg::phase_t phase_reg, phase_next;
    logic [9:0]  seq_reg, seq_next;
    logic [3:0]  flags_reg, flags_next;
    logic [14:0] off_reg, off_next;
    logic        lsf_reg, lsf_next;
    logic        ext_reg, ext_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [6:0]  hi_reg, hi_next;
    logic [3:0]  nib_reg, nib_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [10:0] left_reg, left_next;
    logic        disc_reg, disc_next;
    logic        fresh_reg, fresh_next;
    logic [MAX_SEGMENTS-1:0] nz_reg, nz_next;
    logic [10:0] li_mem [MAX_SEGMENTS];

    logic          li_phase;
    logic          wr_en;
    logic [10:0]   wr_val;
    logic [IW-1:0] wr_idx;
    logic [MAX_SEGMENTS-1:0] nz_cur;
    logic [CW-1:0] cnt_eff;
    logic [CW-1:0] seek_from;
    logic          seek_hit;
    logic [IW-1:0] seek_idx;
    logic [10:0]   seek_val;
    logic [CW-1:0] seek_cur;

    // length indicator write and next nonzero segment search
    always_comb
    begin
        li_phase  = (phase_reg == rlcam_pkg::PH_LIB) || (phase_reg == rlcam_pkg::PH_LIC);
        wr_en     = accept && !disc_reg && li_phase;
        wr_val    = (phase_reg == rlcam_pkg::PH_LIB) ? {hi_reg, pdu_byte[7:4]}
                                                     : {nib_reg[2:0], pdu_byte};
        wr_idx    = cnt_reg[IW-1:0];
        nz_cur    = nz_reg;
        if (li_phase)
        begin
            nz_cur[wr_idx] = (wr_val != 11'd0);
        end
        cnt_eff   = li_phase ? cnt_reg + CW'(1) : cnt_reg;
        seek_from = (phase_reg == rlcam_pkg::PH_DATA) ? cur_reg + CW'(1) : '0;
        seek_hit  = 1'b0;
        seek_idx  = '0;
        for (int i = MAX_SEGMENTS - 1; i >= 0; i--)
        begin
            if (nz_cur[i] && (CW'(i) >= seek_from) && (CW'(i) < cnt_eff))
            begin
                seek_hit = 1'b1;
                seek_idx = IW'(i);
            end
        end
        seek_val = (li_phase && seek_idx == wr_idx) ? wr_val : li_mem[seek_idx];
        seek_cur = seek_hit ? CW'(seek_idx) : cnt_eff;
    end

    logic          err_en;
    logic [1:0]    err_code;
    logic          ent_en;
    logic          emit;
    logic          seg_end_w;
    logic [1:0]    fi;

    // parse step
    always_comb
    begin
        phase_next = phase_reg;
        seq_next   = seq_reg;
        flags_next = flags_reg;
        off_next   = off_reg;
        lsf_next   = lsf_reg;
        ext_next   = ext_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        nib_next   = nib_reg;
        cur_next   = cur_reg;
        left_next  = left_reg;
        disc_next  = disc_reg;
        fresh_next = fresh_reg;
        nz_next    = nz_reg;
        err_en     = 1'b0;
        err_code   = rlcam_pkg::ST_TRUNC;
        ent_en     = 1'b0;
        emit       = 1'b0;
        seg_end_w  = 1'b0;
        fi         = flags_reg[1:0];
        res        = '0;

        if (li_phase)
        begin
            nz_next = nz_cur;
        end

        if (disc_reg)
        begin
            if (pdu_last)
            begin
                disc_next = 1'b0;
            end
            phase_next = rlcam_pkg::PH_HDR0;
        end
        else
        begin
            unique case (phase_reg)
                rlcam_pkg::PH_HDR0:
                begin
                    if (!pdu_byte[7])
                    begin
                        err_en   = 1'b1;
                        err_code = rlcam_pkg::ST_CONTROL;
                    end
                    else
                    begin
                        flags_next = pdu_byte[6:3];
                        ext_next   = pdu_byte[2];
                        seq_next   = {pdu_byte[1:0], 8'd0};
                        off_next   = '0;
                        lsf_next   = 1'b0;
                        cnt_next   = '0;
                        nib_next   = '0;
                        cur_next   = '0;
                        left_next  = '0;
                        phase_next = rlcam_pkg::PH_HDR1;
                        err_en     = pdu_last;
                    end
                end
                rlcam_pkg::PH_HDR1:
                begin
                    seq_next = {seq_reg[9:8], pdu_byte};
                    if (flags_reg[3])
                    begin
                        phase_next = rlcam_pkg::PH_SO0;
                        err_en     = pdu_last;
                    end
                    else if (ext_reg)
                    begin
                        phase_next = rlcam_pkg::PH_LIA;
                        err_en     = pdu_last;
                    end
                    else
                    begin
                        ent_en = 1'b1;
                    end
                end
                rlcam_pkg::PH_SO0:
                begin
                    lsf_next   = pdu_byte[7];
                    off_next   = {pdu_byte[6:0], 8'd0};
                    phase_next = rlcam_pkg::PH_SO1;
                    err_en     = pdu_last;
                end
                rlcam_pkg::PH_SO1:
                begin
                    off_next = {off_reg[14:8], pdu_byte};
                    if (ext_reg)
                    begin
                        phase_next = rlcam_pkg::PH_LIA;
                        err_en     = pdu_last;
                    end
                    else
                    begin
                        ent_en = 1'b1;
                    end
                end
                rlcam_pkg::PH_LIA:
                begin
                    hi_next  = pdu_byte[6:0];
                    ext_next = pdu_byte[7];
                    if (pdu_byte[7] && ((CW + 1)'(cnt_reg) + (CW + 1)'(2) >= MAX_V))
                    begin
                        err_en   = 1'b1;
                        err_code = rlcam_pkg::ST_TOOMANY;
                    end
                    else
                    begin
                        phase_next = rlcam_pkg::PH_LIB;
                        err_en     = pdu_last;
                    end
                end
                rlcam_pkg::PH_LIB:
                begin
                    cnt_next = cnt_eff;
                    if (ext_reg)
                    begin
                        nib_next = pdu_byte[3:0];
                        ext_next = pdu_byte[3];
                        if (pdu_byte[3] && ((CW + 1)'(cnt_eff) + (CW + 1)'(2) >= MAX_V))
                        begin
                            err_en   = 1'b1;
                            err_code = rlcam_pkg::ST_TOOMANY;
                        end
                        else
                        begin
                            phase_next = rlcam_pkg::PH_LIC;
                            err_en     = pdu_last;
                        end
                    end
                    else
                    begin
                        ent_en = 1'b1;
                    end
                end
                rlcam_pkg::PH_LIC:
                begin
                    cnt_next = cnt_eff;
                    if (ext_reg)
                    begin
                        phase_next = rlcam_pkg::PH_LIA;
                        err_en     = pdu_last;
                    end
                    else
                    begin
                        ent_en = 1'b1;
                    end
                end
                rlcam_pkg::PH_DATA:
                begin
                    emit = 1'b1;
                    if (cur_reg >= cnt_reg)
                    begin
                        seg_end_w  = pdu_last;
                        fresh_next = 1'b0;
                        if (pdu_last)
                        begin
                            phase_next = rlcam_pkg::PH_HDR0;
                        end
                    end
                    else
                    begin
                        seg_end_w = (left_reg == 11'd1);
                        left_next = left_reg - 11'd1;
                        if (seg_end_w)
                        begin
                            cur_next   = seek_cur;
                            left_next  = seek_hit ? seek_val : 11'd0;
                            fresh_next = 1'b1;
                        end
                        else
                        begin
                            fresh_next = 1'b0;
                        end
                        if (pdu_last)
                        begin
                            if (!(seg_end_w && seek_cur >= cnt_reg))
                            begin
                                err_en = 1'b1;
                            end
                            phase_next = rlcam_pkg::PH_HDR0;
                        end
                    end
                    // per-segment framing info
                    if (cnt_reg != '0)
                    begin
                        if (cur_reg == '0)
                        begin
                            fi = flags_reg[1:0] & 2'b10;
                        end
                        else if (cur_reg >= cnt_reg)
                        begin
                            fi = flags_reg[1:0] & 2'b01;
                        end
                        else
                        begin
                            fi = 2'b00;
                        end
                    end
                    res.byte_out      = pdu_byte;
                    res.seg_index     = 4'(cur_reg);
                    res.seq_num       = seq_reg;
                    res.resegmented   = flags_reg[3];
                    res.poll_bit      = flags_reg[2];
                    res.framing_info  = fi;
                    res.last_seg_flag = lsf_reg;
                    res.seg_offset    = off_reg;
                    res.seg_start     = fresh_reg;
                    res.seg_end       = seg_end_w;
                    res.status        = rlcam_pkg::ST_DATA;
                    res.pdu_end       = pdu_last;
                end
                default:
                begin
                    phase_next = rlcam_pkg::PH_HDR0;
                end
            endcase

            // start of the data field
            if (ent_en)
            begin
                cur_next   = seek_cur;
                left_next  = seek_hit ? seek_val : 11'd0;
                fresh_next = 1'b1;
                phase_next = rlcam_pkg::PH_DATA;
                if (pdu_last)
                begin
                    if (seek_cur < cnt_eff)
                    begin
                        err_en = 1'b1;
                    end
                    else
                    begin
                        phase_next = rlcam_pkg::PH_HDR0;
                    end
                end
            end

            // error result ends the pdu
            if (err_en)
            begin
                res         = '0;
                res.status  = err_code;
                res.pdu_end = 1'b1;
                emit        = 1'b1;
                phase_next  = rlcam_pkg::PH_HDR0;
                disc_next   = !pdu_last;
            end
        end
        res_valid = accept && emit;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rlcam_pkg::PH_HDR0;
            seq_reg   <= '0;
            flags_reg <= '0;
            off_reg   <= '0;
            lsf_reg   <= 1'b0;
            ext_reg   <= 1'b0;
            cnt_reg   <= '0;
            hi_reg    <= '0;
            nib_reg   <= '0;
            cur_reg   <= '0;
            left_reg  <= '0;
            disc_reg  <= 1'b0;
            fresh_reg <= 1'b0;
            nz_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            seq_reg   <= seq_next;
            flags_reg <= flags_next;
            off_reg   <= off_next;
            lsf_reg   <= lsf_next;
            ext_reg   <= ext_next;
            cnt_reg   <= cnt_next;
            hi_reg    <= hi_next;
            nib_reg   <= nib_next;
            cur_reg   <= cur_next;
            left_reg  <= left_next;
            disc_reg  <= disc_next;
            fresh_reg <= fresh_next;
            nz_reg    <= nz_next;
        end
    end

    // length indicator store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            li_mem[wr_idx] <= wr_val;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/rlcam_queue.sv */
`default_nettype none
`include "rlc_am_pdu_deframer_assert.svh"
module rlcam_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire rlcam_pkg::res_t push_data,
    output logic                 push_ready,
    output logic                 pop_valid,
    output rlcam_pkg::res_t      pop_data,
    input  wire logic            pop
);

    rlcam_pkg::res_t ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    // pointer and fill count update
    always_comb
    begin
        push_ready  = (cnt_reg != 2'd2);
        pop_valid   = (cnt_reg != 2'd0);
        pop_data    = ent_reg[rd_ptr_reg];
        do_push     = push && push_ready;
        do_pop      = pop && pop_valid;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    `RLCAM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg != 2'd3)
    `RLCAM_ASSERT_NXT(a_push_shows, do_push && !do_pop, pop_valid)
    `RLCAM_ASSERT_IMP(a_ptr_track, cnt_reg == 2'd0 || cnt_reg == 2'd2, wr_ptr_reg == rd_ptr_reg)

endmodule
`default_nettype wire

/* hw/rtl/rlc_am_pdu_deframer.sv */
// output: a result item is registered in the result queue when its byte is taken
// throughput: one pdu byte per cycle unless the result queue is full; a two-entry
// queue decouples the parser from the output so a byte is taken while an earlier
// result still waits; header and length indicator bytes give only error results
// reset: rst_n is asynchronous, active low, and returns the parser to the header phase
`default_nettype none
module rlc_am_pdu_deframer #(
    parameter int MAX_SEGMENTS = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rlcam_byte_if.sink   pdu_in,
    rlcam_res_if.source  res_out
);

    logic            q_ready;
    logic            accept;
    logic            res_valid;
    rlcam_pkg::res_t res;
    rlcam_pkg::res_t q_data;

    assign pdu_in.ready = q_ready;
    assign accept       = pdu_in.valid && q_ready;

    // front: byte parser
    rlcam_parser #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .pdu_byte  (pdu_in.pdu_byte),
        .pdu_last  (pdu_in.pdu_last),
        .res       (res),
        .res_valid (res_valid)
    );

    // back: result queue and output
    rlcam_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .push_ready (q_ready),
        .pop_valid  (res_out.valid),
        .pop_data   (q_data),
        .pop        (res_out.ready)
    );

    assign res_out.byte_out      = q_data.byte_out;
    assign res_out.seg_index     = q_data.seg_index;
    assign res_out.seq_num       = q_data.seq_num;
    assign res_out.resegmented   = q_data.resegmented;
    assign res_out.poll_bit      = q_data.poll_bit;
    assign res_out.framing_info  = q_data.framing_info;
    assign res_out.last_seg_flag = q_data.last_seg_flag;
    assign res_out.seg_offset    = q_data.seg_offset;
    assign res_out.seg_start     = q_data.seg_start;
    assign res_out.seg_end       = q_data.seg_end;
    assign res_out.status        = q_data.status;
    assign res_out.pdu_end       = q_data.pdu_end;

endmodule
`default_nettype wire
